// ===== rtl/arrt_pkg.sv =====
package arrt_pkg;

  // Table geometry and address width
  localparam int unsigned NUM_RANGES = 8;
  localparam int unsigned ADDR_BITS  = 48;
  localparam int unsigned IDX_W      = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;

  // Publisher counter limits
  localparam int unsigned MAX_PUBLISHERS = 65535;
  localparam int unsigned COUNT_CAP      = 65535;
  localparam int unsigned PUB_CEIL       =
      (MAX_PUBLISHERS < COUNT_CAP) ? MAX_PUBLISHERS : COUNT_CAP;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LIFE_W   = 2;
  localparam int unsigned PUB_W    = 16;
  localparam int unsigned LIMIT_W  = 48;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 48'h8000_0000_0000;

  typedef enum logic [OP_W-1:0] {
    OP_RESERVE   = 3'd0,
    OP_RELEASE   = 3'd1,
    OP_CONTAINS  = 3'd2,
    OP_OVERLAPS  = 3'd3,
    OP_PUBLISH   = 3'd4,
    OP_UNPUBLISH = 3'd5,
    OP_RETIRE    = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_LIFE    = 2'd3
  } status_t;

  typedef enum logic [LIFE_W-1:0] {
    LIFE_BUILDING = 2'd0,
    LIFE_ACTIVE   = 2'd1,
    LIFE_RETIRING = 2'd2
  } life_t;

endpackage

// ===== rtl/arrt_if.sv =====
// Request channel: one table or lifecycle operation per transfer.
interface arrt_req_if;
  import arrt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [ADDR_BITS-1:0] start_addr;
  logic [ADDR_BITS-1:0] end_addr;
  logic                 region_kind;

  modport source (output valid, operation, start_addr, end_addr, region_kind,
                  input ready);
  modport sink   (input valid, operation, start_addr, end_addr, region_kind,
                  output ready);
endinterface

// Response channel: one result per request.
interface arrt_rsp_if;
  import arrt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                hit;
  logic [LIFE_W-1:0]   life_state;
  logic [PUB_W-1:0]    publisher_count;

  modport source (output valid, status, hit, life_state, publisher_count,
                  input ready);
  modport sink   (input valid, status, hit, life_state, publisher_count,
                  output ready);
endinterface

// ===== rtl/address_region_reservation_table_unit.sv =====
// Sequence from request transfer to response valid: a check step, a scan of up to NUM_RANGES
//   entries (one entry per cycle through one compare unit), a fill step for a new reservation,
//   and a load of the response register once the previous response has left it.
// A new request is taken only in the idle state, after the current one has finished.
// A finished response waits in its own register while the next request is taken.
// Reset (rst, synchronous): table empty, lifecycle building, no publishers, limit 2^47.
module address_region_reservation_table_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [arrt_pkg::LIMIT_W-1:0] cfg_wr_data,
  arrt_req_if.sink                     req,
  arrt_rsp_if.source                   rsp
);
  import arrt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_SCAN  = 5'b00100,
    S_FILL  = 5'b01000,
    S_DONE  = 5'b10000
  } seq_t;

  seq_t state;

  // Configuration and lifecycle
  logic [LIMIT_W-1:0] user_space_limit;
  life_t              life;
  logic [PUB_W-1:0]   pub;

  // Range table
  logic [ADDR_BITS-1:0] range_start [NUM_RANGES];
  logic [ADDR_BITS-1:0] range_end   [NUM_RANGES];
  logic                 range_kind  [NUM_RANGES];
  logic [NUM_RANGES-1:0] range_valid;

  // Latched request and scan control
  logic [OP_W-1:0]      op;
  logic [ADDR_BITS-1:0] s_addr;
  logic [ADDR_BITS-1:0] e_addr;
  logic                 kind;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     free_idx;
  logic                 free_found;
  status_t              res_status;
  logic                 res_hit;

  // Response register
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic                out_hit;
  logic [LIFE_W-1:0]   out_life;
  logic [PUB_W-1:0]    out_pub;

  // Shared compare unit on the entry under the scan index
  logic [ADDR_BITS-1:0] cur_start;
  logic [ADDR_BITS-1:0] cur_end;
  logic                 cur_valid;
  logic                 hit_exact;
  logic                 hit_touch;
  logic                 hit_cover;
  logic                 last_idx;

  assign cur_start = range_start[idx];
  assign cur_end   = range_end[idx];
  assign cur_valid = range_valid[idx];
  assign hit_exact = cur_valid && (cur_start == s_addr) && (cur_end == e_addr) &&
                     (range_kind[idx] == kind);
  assign hit_touch = cur_valid && (s_addr < cur_end) && (e_addr > cur_start);
  assign hit_cover = cur_valid && (s_addr >= cur_start) && (s_addr < cur_end);
  assign last_idx  = (idx == IDX_W'(NUM_RANGES - 1));

  // Reserve admission checks
  logic reserve_ok;
  assign reserve_ok = (life == LIFE_BUILDING) && (s_addr != '0) && (s_addr < e_addr) &&
                      ((ADDR_BITS > LIMIT_W) ? (e_addr <= ADDR_BITS'(user_space_limit))
                                             : (LIMIT_W'(e_addr) <= user_space_limit));

  assign req.ready = (state == S_IDLE);

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.hit             = out_hit;
  assign rsp.life_state      = out_life;
  assign rsp.publisher_count = out_pub;

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      user_space_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      user_space_limit <= cfg_wr_data;
    end
  end

  // Sequencer, table and lifecycle updates
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      life        <= LIFE_BUILDING;
      pub         <= '0;
      range_valid <= '0;
      idx         <= '0;
      free_found  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op         <= req.operation;
            s_addr     <= req.start_addr;
            e_addr     <= req.end_addr;
            kind       <= req.region_kind;
            idx        <= '0;
            free_found <= 1'b0;
            res_status <= ST_OK;
            res_hit    <= 1'b0;
            state      <= S_CHECK;
          end
        end

        // Operations that need no scan settle here
        S_CHECK: begin
          state <= S_DONE;
          case (op)
            OP_RESERVE: begin
              if (reserve_ok) begin
                state <= S_SCAN;
              end else begin
                res_status <= ST_INVALID;
              end
            end
            OP_RELEASE, OP_CONTAINS: begin
              state <= S_SCAN;
            end
            OP_OVERLAPS: begin
              if (s_addr < e_addr) begin
                state <= S_SCAN;
              end
            end
            OP_PUBLISH: begin
              if ((life inside {LIFE_BUILDING, LIFE_ACTIVE}) &&
                  (pub < PUB_W'(PUB_CEIL))) begin
                life <= LIFE_ACTIVE;
                pub  <= pub + PUB_W'(1);
              end else begin
                res_status <= ST_LIFE;
              end
            end
            OP_UNPUBLISH: begin
              if ((life == LIFE_ACTIVE) && (pub != '0)) begin
                life <= (pub == PUB_W'(1)) ? LIFE_RETIRING : LIFE_ACTIVE;
                pub  <= pub - PUB_W'(1);
              end else begin
                res_status <= ST_LIFE;
              end
            end
            OP_RETIRE: begin
              if ((pub == '0) && (life inside {LIFE_BUILDING, LIFE_RETIRING})) begin
                life <= LIFE_RETIRING;
              end else begin
                res_status <= ST_LIFE;
              end
            end
            default: begin
              res_status <= ST_INVALID;
            end
          endcase
        end

        // One entry per cycle, in index order
        S_SCAN: begin
          idx <= idx + IDX_W'(1);
          case (op)
            OP_RESERVE: begin
              if (hit_exact) begin
                state <= S_DONE;
              end else if (hit_touch) begin
                res_status <= ST_INVALID;
                state      <= S_DONE;
              end else begin
                if (!cur_valid && !free_found) begin
                  free_idx   <= idx;
                  free_found <= 1'b1;
                end
                if (last_idx) begin
                  if (free_found || !cur_valid) begin
                    state <= S_FILL;
                  end else begin
                    res_status <= ST_FULL;
                    state      <= S_DONE;
                  end
                end
              end
            end
            OP_RELEASE: begin
              if (hit_exact) begin
                range_valid[idx] <= 1'b0;
                res_hit          <= 1'b1;
                state            <= S_DONE;
              end else if (last_idx) begin
                state <= S_DONE;
              end
            end
            OP_CONTAINS: begin
              if (hit_cover) begin
                res_hit <= 1'b1;
                state   <= S_DONE;
              end else if (last_idx) begin
                state <= S_DONE;
              end
            end
            default: begin
              if (hit_touch) begin
                res_hit <= 1'b1;
                state   <= S_DONE;
              end else if (last_idx) begin
                state <= S_DONE;
              end
            end
          endcase
        end

        S_FILL: begin
          range_valid[free_idx] <= 1'b1;
          state                 <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Entry payload written on a fill
  always_ff @(posedge clk) begin
    if (state == S_FILL) begin
      range_start[free_idx] <= s_addr;
      range_end[free_idx]   <= e_addr;
      range_kind[free_idx]  <= kind;
    end
  end

  // Response register: loaded when the sequencer finishes, freed by a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!out_valid || rsp.ready)) begin
      out_status <= res_status;
      out_hit    <= res_hit;
      out_life   <= life;
      out_pub    <= pub;
    end
  end

  // Any publisher means the lifecycle is active
  a_pub_active: assert property (@(posedge clk) disable iff (rst)
    (pub != '0) |-> (life == LIFE_ACTIVE))
    else $error("publishers present outside the active state");

  // Retiring is final
  a_retire_final: assert property (@(posedge clk) disable iff (rst)
    (life == LIFE_RETIRING) |=> (life == LIFE_RETIRING))
    else $error("lifecycle left the retiring state");

  // A fill only ever takes a free slot
  a_fill_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> !range_valid[free_idx])
    else $error("fill into an occupied slot");

  // A new response only follows the end of a sequence
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("response raised outside the done step");

endmodule

// ===== sim/address_region_reservation_table_unit_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the reservation table, keeps its own copy of the
// table and the lifecycle word, and compares each response transfer with the
// oldest predicted reply.
module address_region_reservation_table_unit_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [arrt_pkg::LIMIT_W-1:0] cfg_wr_data,
  arrt_req_if                          req,
  arrt_rsp_if                          rsp,
  output int unsigned                  mismatches,
  output int unsigned                  outstanding
);
  import arrt_pkg::*;

  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef struct packed {
    status_t          status;
    logic             hit;
    life_t            life_state;
    logic [PUB_W-1:0] publisher_count;
  } reply_t;

  // Shadow copy of the table, the lifecycle word and the limit register.
  addr_t              span_lo   [NUM_RANGES];
  addr_t              span_hi   [NUM_RANGES];
  logic               span_kind [NUM_RANGES];
  logic               span_used [NUM_RANGES];
  life_t              life;
  logic [PUB_W-1:0]   pub_count;
  logic [LIMIT_W-1:0] space_limit;

  reply_t      pending_replies [$];
  int unsigned errors;
  int unsigned reply_no;

  // Applies one request to the shadow state and returns the reply it earns.
  function automatic reply_t apply_table_op(logic [OP_W-1:0] op, addr_t s, addr_t e,
                                            logic k);
    reply_t r;
    logic   done;
    r.status = ST_OK;
    r.hit    = 1'b0;
    done     = 1'b0;
    case (op)
      OP_RESERVE: begin
        if (life != LIFE_BUILDING || s == '0 || s >= e || e > space_limit) begin
          r.status = ST_INVALID;
        end else begin
          // An exact duplicate is accepted; any other overlap is refused.
          for (int i = 0; i < NUM_RANGES; i++) begin
            if (!done && span_used[i]) begin
              if (span_lo[i] == s && span_hi[i] == e && span_kind[i] == k) begin
                done = 1'b1;
              end else if (s < span_hi[i] && e > span_lo[i]) begin
                done     = 1'b1;
                r.status = ST_INVALID;
              end
            end
          end
          // Otherwise the lowest free slot takes the range.
          for (int i = 0; i < NUM_RANGES; i++) begin
            if (!done && !span_used[i]) begin
              span_lo[i]   = s;
              span_hi[i]   = e;
              span_kind[i] = k;
              span_used[i] = 1'b1;
              done         = 1'b1;
            end
          end
          if (!done) r.status = ST_FULL;
        end
      end
      OP_RELEASE: begin
        for (int i = 0; i < NUM_RANGES; i++) begin
          if (!done && span_used[i] && span_lo[i] == s && span_hi[i] == e &&
              span_kind[i] == k) begin
            span_lo[i]   = '0;
            span_hi[i]   = '0;
            span_kind[i] = 1'b0;
            span_used[i] = 1'b0;
            r.hit        = 1'b1;
            done         = 1'b1;
          end
        end
      end
      OP_CONTAINS: begin
        for (int i = 0; i < NUM_RANGES; i++) begin
          if (span_used[i] && s >= span_lo[i] && s < span_hi[i]) r.hit = 1'b1;
        end
      end
      OP_OVERLAPS: begin
        // An empty probe range never overlaps anything.
        if (s < e) begin
          for (int i = 0; i < NUM_RANGES; i++) begin
            if (span_used[i] && s < span_hi[i] && e > span_lo[i]) r.hit = 1'b1;
          end
        end
      end
      OP_PUBLISH: begin
        if ((life == LIFE_BUILDING || life == LIFE_ACTIVE) && 32'(pub_count) < PUB_CEIL) begin
          life      = LIFE_ACTIVE;
          pub_count = pub_count + 16'd1;
        end else begin
          r.status = ST_LIFE;
        end
      end
      OP_UNPUBLISH: begin
        if (life == LIFE_ACTIVE && pub_count != '0) begin
          life      = (pub_count == 16'd1) ? LIFE_RETIRING : LIFE_ACTIVE;
          pub_count = pub_count - 16'd1;
        end else begin
          r.status = ST_LIFE;
        end
      end
      OP_RETIRE: begin
        if (pub_count == '0 && (life == LIFE_BUILDING || life == LIFE_RETIRING)) begin
          life = LIFE_RETIRING;
        end else begin
          r.status = ST_LIFE;
        end
      end
      default: r.status = ST_INVALID;
    endcase
    r.life_state      = life;
    r.publisher_count = pub_count;
    return r;
  endfunction

  // Response transfers are checked before the request transfer of the same edge is predicted.
  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (rst) begin
      for (int i = 0; i < NUM_RANGES; i++) begin
        span_lo[i]   = '0;
        span_hi[i]   = '0;
        span_kind[i] = 1'b0;
        span_used[i] = 1'b0;
      end
      life        = LIFE_BUILDING;
      pub_count   = '0;
      space_limit = LIMIT_RESET;
      pending_replies.delete();
      errors      = 0;
      reply_no    = 0;
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_wr_en) space_limit = cfg_wr_data;

      if (rsp.valid && rsp.ready) begin
        got.status          = status_t'(rsp.status);
        got.hit             = rsp.hit;
        got.life_state      = life_t'(rsp.life_state);
        got.publisher_count = rsp.publisher_count;
        if (pending_replies.size() == 0) begin
          if (errors < 10) begin
            $display("reply %0d: unexpected response, status %0d hit %0d life %0d count %0d",
                     reply_no, got.status, got.hit, got.life_state, got.publisher_count);
          end
          errors++;
        end else begin
          want = pending_replies.pop_front();
          if (got != want) begin
            if (errors < 10) begin
              $display("reply %0d: expected status %0d hit %0d life %0d count %0d",
                       reply_no, want.status, want.hit, want.life_state,
                       want.publisher_count);
              $display("reply %0d: actual   status %0d hit %0d life %0d count %0d",
                       reply_no, got.status, got.hit, got.life_state, got.publisher_count);
            end
            errors++;
          end
        end
        reply_no++;
      end

      if (req.valid && req.ready) begin
        pending_replies.push_back(apply_table_op(req.operation, req.start_addr,
                                                 req.end_addr, req.region_kind));
      end

      mismatches  <= errors;
      outstanding <= pending_replies.size();
    end
  end

endmodule

// ===== sim/address_region_reservation_table_unit_tb.sv =====
`timescale 1ns / 1ps

module address_region_reservation_table_unit_tb;
  import arrt_pkg::*;

  typedef logic [ADDR_BITS-1:0] addr_t;

  localparam logic [OP_W-1:0] OP_UNDEFINED    = 3'd7;
  localparam int unsigned     STALL_LIMIT     = 2000;
  localparam int unsigned     HOLD_OFF_CYCLES = 300;
  localparam int unsigned     HIST_DEPTH      = 16;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_wr_en;
  logic [LIMIT_W-1:0] cfg_wr_data;
  int unsigned        mismatches;
  int unsigned        outstanding;

  arrt_req_if req_ch ();
  arrt_rsp_if rsp_ch ();

  // Stimulus-side knowledge: current limit, lifecycle progress and recent ranges.
  addr_t       limit_now;
  int unsigned burst_left;
  int unsigned pub_level;
  logic        published;
  addr_t       hist_s [HIST_DEPTH];
  addr_t       hist_e [HIST_DEPTH];
  logic        hist_k [HIST_DEPTH];
  int unsigned hist_n;
  int unsigned hist_w;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  address_region_reservation_table_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  address_region_reservation_table_unit_checker reply_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  function automatic addr_t rand_addr();
    return addr_t'({$urandom, $urandom});
  endfunction

  // Offers one request and returns at the edge of its transfer. Requests go out
  // in bursts; valid is dropped between bursts.
  task automatic send_req(input logic [OP_W-1:0] op, input addr_t s, input addr_t e,
                          input logic k);
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 24);
    end
    burst_left--;
    req_ch.valid       <= 1'b1;
    req_ch.operation   <= op;
    req_ch.start_addr  <= s;
    req_ch.end_addr    <= e;
    req_ch.region_kind <= k;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Stops offering and waits until every predicted reply has been received.
  task automatic drain();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_limit(input addr_t value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_now = value;
  endtask

  // A new range: low memory, just under the limit, anywhere page aligned, or anywhere.
  task automatic fresh_range(output addr_t s, output addr_t e);
    addr_t base;
    addr_t len;
    case ($urandom_range(0, 3))
      0: base = addr_t'($urandom_range(1, 32) << 12);
      1: begin
        if (limit_now > addr_t'(32'h0004_0000)) begin
          base = limit_now - addr_t'($urandom_range(1, 32) << 12);
        end else begin
          base = addr_t'($urandom_range(1, 32) << 12);
        end
      end
      2: base = rand_addr() & ~addr_t'(12'hFFF);
      default: base = rand_addr();
    endcase
    if ($urandom_range(0, 7) == 0) len = addr_t'($urandom_range(1, 4095));
    else len = addr_t'($urandom_range(1, 4) << 12);
    s = base;
    e = base + len;
  endtask

  task automatic recall_range(output addr_t s, output addr_t e, output logic k);
    int unsigned idx;
    idx = $urandom_range(0, hist_n - 1);
    s = hist_s[idx];
    e = hist_e[idx];
    k = hist_k[idx];
  endtask

  // One random table request; most are well formed and many reuse recent ranges so
  // that duplicates, overlaps and releases find their targets.
  task automatic table_item();
    addr_t       s;
    addr_t       e;
    addr_t       t;
    logic        k;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    k    = 1'($urandom_range(0, 1));
    if (pick < 40) begin
      if (hist_n != 0 && $urandom_range(0, 3) == 0) recall_range(s, e, k);
      else fresh_range(s, e);
      hist_s[hist_w] = s;
      hist_e[hist_w] = e;
      hist_k[hist_w] = k;
      hist_w = (hist_w + 1) % HIST_DEPTH;
      if (hist_n < HIST_DEPTH) hist_n++;
      send_req(OP_RESERVE, s, e, k);
    end else if (pick < 62) begin
      if (hist_n != 0 && $urandom_range(0, 9) < 7) recall_range(s, e, k);
      else fresh_range(s, e);
      send_req(OP_RELEASE, s, e, k);
    end else if (pick < 77) begin
      if (hist_n != 0) recall_range(s, e, k);
      else fresh_range(s, e);
      // Probe on and around the edges of the range.
      case ($urandom_range(0, 4))
        0: t = s;
        1: t = e - addr_t'(1);
        2: t = e;
        3: t = s - addr_t'(1);
        default: t = rand_addr();
      endcase
      send_req(OP_CONTAINS, t, rand_addr(), k);
    end else if (pick < 90) begin
      if (hist_n != 0 && $urandom_range(0, 1) == 0) recall_range(s, e, k);
      else fresh_range(s, e);
      if ($urandom_range(0, 5) == 0) send_req(OP_OVERLAPS, e, s, k);
      else send_req(OP_OVERLAPS, s, e, k);
    end else begin
      // Noise: an undefined code, a refused lifecycle change, or garbage fields.
      case ($urandom_range(0, 3))
        0: send_req(OP_UNDEFINED, rand_addr(), rand_addr(), k);
        1: send_req(published ? OP_RETIRE : OP_UNPUBLISH, rand_addr(), rand_addr(), k);
        2: send_req(OP_RESERVE, rand_addr(), rand_addr(), k);
        default: send_req(3'($urandom_range(0, 3)), rand_addr(), rand_addr(), k);
      endcase
    end
  endtask

  task automatic publish_one();
    send_req(OP_PUBLISH, rand_addr(), rand_addr(), 1'($urandom_range(0, 1)));
    pub_level++;
    published = 1'b1;
  endtask

  task automatic unpublish_one();
    send_req(OP_UNPUBLISH, rand_addr(), rand_addr(), 1'($urandom_range(0, 1)));
    pub_level--;
  endtask

  // Receiver pacing: a rotating stall pattern, plus two long hold-offs that
  // back the block up while the sender keeps offering.
  initial begin : rsp_pacing
    int unsigned tick;
    int unsigned taken;
    int unsigned hold_left;
    int unsigned holds_done;
    tick         = 0;
    taken        = 0;
    hold_left    = 0;
    holds_done   = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) taken++;
      tick++;
      if (hold_left == 0 && holds_done < 2 && taken >= ((holds_done == 0) ? 120 : 300)) begin
        hold_left = HOLD_OFF_CYCLES;
        holds_done++;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (tick[8:7])
          2'd0: rsp_ch.ready <= 1'b1;
          2'd1: rsp_ch.ready <= 1'($urandom_range(0, 1));
          2'd2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ch.ready <= tick[2];
        endcase
      end
    end
  end

  // Ends the run when no transfer has happened on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned pick;
    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    req_ch.valid       = 1'b0;
    req_ch.operation   = OP_RESERVE;
    req_ch.start_addr  = '0;
    req_ch.end_addr    = '0;
    req_ch.region_kind = 1'b0;
    limit_now          = LIMIT_RESET;
    burst_left         = 0;
    pub_level          = 0;
    published          = 1'b0;
    hist_n             = 0;
    hist_w             = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, malformed reserves, duplicates, overlaps, a full table.
    send_req(OP_CONTAINS, '0, '0, 1'b0);
    send_req(OP_OVERLAPS, '0, '1, 1'b1);
    send_req(OP_RESERVE, '0, addr_t'(32'h2000), 1'b0);
    send_req(OP_RESERVE, addr_t'(32'h3000), addr_t'(32'h3000), 1'b0);
    send_req(OP_RESERVE, addr_t'(32'h1000), LIMIT_RESET + addr_t'(1), 1'b0);
    send_req(OP_RESERVE, LIMIT_RESET - addr_t'(32'h1000), LIMIT_RESET, 1'b1);
    send_req(OP_RESERVE, addr_t'(32'h1000), addr_t'(32'h2000), 1'b0);
    send_req(OP_RESERVE, addr_t'(32'h1000), addr_t'(32'h2000), 1'b0);
    send_req(OP_RESERVE, addr_t'(32'h1000), addr_t'(32'h2000), 1'b1);
    send_req(OP_RESERVE, addr_t'(32'h1800), addr_t'(32'h2800), 1'b0);
    send_req(OP_RESERVE, addr_t'(32'h2000), addr_t'(32'h3000), 1'b1);
    send_req(OP_CONTAINS, addr_t'(32'h1FFF), '1, 1'b0);
    send_req(OP_CONTAINS, '1, '0, 1'b1);
    send_req(OP_OVERLAPS, addr_t'(32'h2FFF), addr_t'(32'h1000), 1'b0);
    send_req(OP_OVERLAPS, addr_t'(32'h2FFF), addr_t'(32'h3000), 1'b0);
    for (int i = 1; i <= 5; i++) begin
      send_req(OP_RESERVE, addr_t'(i << 16), addr_t'((i << 16) + 32'h1000), 1'(i));
    end
    send_req(OP_RESERVE, addr_t'(32'h9_0000), addr_t'(32'h9_1000), 1'b0);
    send_req(OP_RELEASE, addr_t'(32'h2000), addr_t'(32'h3000), 1'b0);
    send_req(OP_RELEASE, addr_t'(32'h2000), addr_t'(32'h3000), 1'b1);
    send_req(OP_UNDEFINED, '1, '1, 1'b1);
    send_req(OP_UNPUBLISH, '0, '0, 1'b0);

    // Random table traffic while building, under several limits.
    repeat (150) table_item();
    set_limit('1);
    repeat (150) table_item();
    set_limit(addr_t'(1));
    repeat (20) table_item();
    set_limit(rand_addr() | addr_t'(32'h0010_0000));
    repeat (100) table_item();
    set_limit(addr_t'(32'h0002_0000));
    repeat (100) table_item();
    drain();

    // The lifecycle only moves forward, so it is exercised last.
    publish_one();
    send_req(OP_RESERVE, addr_t'(32'h1000), addr_t'(32'h2000), 1'b0);
    send_req(OP_RETIRE, '0, '0, 1'b0);
    publish_one();
    unpublish_one();
    repeat (100) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        publish_one();
      end else if (pick < 40) begin
        if (pub_level > 1) unpublish_one();
        else publish_one();
      end else if (pick < 48) begin
        send_req(OP_RETIRE, rand_addr(), rand_addr(), 1'($urandom_range(0, 1)));
      end else begin
        table_item();
      end
    end

    // Raise the publisher count a little further, try to retire, then count down to retiring.
    repeat (6) publish_one();
    send_req(OP_RETIRE, '0, '0, 1'b0);
    while (pub_level > 0) unpublish_one();

    // Retiring: further lifecycle changes are refused, retire itself is harmless.
    send_req(OP_PUBLISH, '0, '0, 1'b0);
    send_req(OP_UNPUBLISH, '0, '0, 1'b0);
    send_req(OP_RETIRE, '0, '0, 1'b0);
    send_req(OP_RETIRE, '1, '1, 1'b1);
    send_req(OP_RESERVE, addr_t'(32'h4000), addr_t'(32'h5000), 1'b0);
    repeat (40) table_item();

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
